[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants for the sorted priority queue
// Field widths, command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int KEY_W         = 16;
  localparam int ID_W          = 30;
  localparam int OCC_W         = 5;
  localparam int DEFAULT_DEPTH = 16;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell in the chain each cycle.
  typedef struct packed {
    logic             push;    // insert accepted this cycle
    logic             pop;     // head removal accepted this cycle
    logic [KEY_W-1:0] key;     // key of the new entry
    logic [ID_W-1:0]  id;      // id of the new entry
  } cell_ctrl_t;

endpackage

[src/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell - one slot of the shift-register priority queue
// Holds one entry; on push it keeps, loads the new entry or takes its left
// neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                       clk,
  input  spq_pkg::cell_ctrl_t        ctrl,
  input  logic                       occ,        // slot holds a live entry
  input  logic                       left_ge,    // left slot keeps its entry
  input  logic [spq_pkg::KEY_W-1:0]  left_key,
  input  logic [spq_pkg::ID_W-1:0]   left_id,
  input  logic [spq_pkg::KEY_W-1:0]  right_key,
  input  logic [spq_pkg::ID_W-1:0]   right_id,
  output logic                       ge,
  output logic [spq_pkg::KEY_W-1:0]  key,
  output logic [spq_pkg::ID_W-1:0]   id
);

  logic [spq_pkg::KEY_W-1:0] key_next;
  logic [spq_pkg::ID_W-1:0]  id_next;

  // Sorted order makes ge a prefix of the chain; equal keys stay ahead.
  assign ge = occ && (key >= ctrl.key);

  always_comb begin
    key_next = key;
    id_next  = id;
    if (ctrl.pop) begin
      key_next = right_key;
      id_next  = right_id;
    end else if (ctrl.push && !ge) begin
      if (left_ge) begin
        key_next = ctrl.key;
        id_next  = ctrl.id;
      end else begin
        key_next = left_key;
        id_next  = left_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    id  <= id_next;
  end

endmodule

[src/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_top - bounded priority queue in descending key order
// A row of cells shifts right to open a slot on push and shifts left on pop.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+---------------------------
//  s_*     | in  | priority_key, item_id          | command (0 push, 1 pop)
//  m_*     | out | popped_key, popped_id, occupancy | status, popped_valid
//
// One word in, one word out. Every cell compares its key to the incoming
// key in the same cycle, so a command is taken every clock while the output
// register can take its result, by the compare-and-shift of the cell row.
// The result sits in an output register; a new word is accepted whenever
// that register is empty or is being read in the same cycle.
// rst clears the entry count and the output valid; cell contents are not
// reset and only slots below the count are ever read.
//
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [15:0] priority_key, [45:16] item_id, rest 0
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [15:0] popped_key, [45:16] popped_id,
                                 // [50:46] occupancy, rest 0
  output logic [2:0]  m_tuser    // [1:0] status, [2] popped_valid
);

  localparam int KW    = spq_pkg::KEY_W;
  localparam int IW    = spq_pkg::ID_W;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Entry count and output register.
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 out_valid;
  spq_pkg::status_t     out_status;
  logic                 out_pvalid;
  logic [KW-1:0]        out_key;
  logic [IW-1:0]        out_id;
  logic [spq_pkg::OCC_W-1:0] out_occ;

  logic                 accept;
  logic                 is_pop;
  logic                 empty;
  logic                 full;
  spq_pkg::cell_ctrl_t  ctrl;

  logic [KW-1:0]        cell_key [QUEUE_DEPTH];
  logic [IW-1:0]        cell_id  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  logic [QUEUE_DEPTH-1:0] cell_occ;

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_pop   = (s_tuser == spq_pkg::CMD_POP);
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(QUEUE_DEPTH));

  // Shift only for commands that change the queue.
  assign ctrl.push = accept && !is_pop && !full;
  assign ctrl.pop  = accept && is_pop && !empty;
  assign ctrl.key  = s_tdata[KW-1:0];
  assign ctrl.id   = s_tdata[KW+IW-1:KW];

  // Cell row: slot 0 holds the highest key.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic          l_ge;
    logic [KW-1:0] l_key;
    logic [IW-1:0] l_id;
    logic [KW-1:0] r_key;
    logic [IW-1:0] r_id;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign l_ge  = 1'b1;
      assign l_key = ctrl.key;
      assign l_id  = ctrl.id;
    end else begin : g_body
      assign l_ge  = cell_ge[i-1];
      assign l_key = cell_key[i-1];
      assign l_id  = cell_id[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_key = cell_key[i];
      assign r_id  = cell_id[i];
    end else begin : g_mid
      assign r_key = cell_key[i+1];
      assign r_id  = cell_id[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (cell_occ[i]),
      .left_ge   (l_ge),
      .left_key  (l_key),
      .left_id   (l_id),
      .right_key (r_key),
      .right_id  (r_id),
      .ge        (cell_ge[i]),
      .key       (cell_key[i]),
      .id        (cell_id[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_occ <= spq_pkg::OCC_W'(count_next);
      if (is_pop) begin
        out_status <= empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
        out_pvalid <= !empty;
        out_key    <= empty ? '0 : cell_key[0];
        out_id     <= empty ? '0 : cell_id[0];
      end else begin
        out_status <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        out_pvalid <= 1'b0;
        out_key    <= '0;
        out_id     <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_occ, out_id, out_key};
  assign m_tuser  = {out_pvalid, out_status};

endmodule
